// ===== design/crp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants for the cursor position report parser: field
// widths, character codes, result kinds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int BYTE_W  = 8;
    localparam int NUM_W   = 16;
    localparam int KIND_W  = 2;
    localparam int LIMIT_W = 9;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
    localparam logic [NUM_W-1:0]   NUM_MAX     = 16'hFFFF;

    // Input commands
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CHAR_ESC  = 8'h1B;
    localparam logic [BYTE_W-1:0] CHAR_LBRK = 8'h5B;
    localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CHAR_R    = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;

    typedef enum logic [KIND_W-1:0] {
        KIND_CARRY  = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_FAIL   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_BUF,
        EMIT_BYTE,
        EMIT_REPORT,
        EMIT_FAIL
    } emit_t;

    typedef enum logic [1:0] {
        PEND_HOLD,
        PEND_APPEND,
        PEND_START,
        PEND_CLEAR
    } pend_op_t;

    typedef struct packed {
        logic     load_in;
        logic     flush_init;
        pend_op_t pend_op;
        emit_t    emit;
        logic     last;
        logic     end_wait;
    } crp_cmd_t;

    typedef struct packed {
        logic fail_pre;
        logic empty;
        logic is_esc;
        logic fits;
        logic is_r;
        logic parse_ok;
        logic post_fail;
        logic flush_last;
        logic slot_free;
    } crp_status_t;

endpackage : crp_pkg
`default_nettype wire

// ===== design/crp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crp_datapath
// Pending sequence buffer, running row/column parse, carried byte count and
// the registered result slot.
// ----------------------------------------------------------------------------
module crp_datapath #(
    parameter int SEQ_BYTES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        command,
    input  wire logic [crp_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic [crp_pkg::LIMIT_W-1:0] carry_limit,
    input  wire crp_pkg::crp_cmd_t           cmd,
    output crp_pkg::crp_status_t             status,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [crp_pkg::KIND_W-1:0]       kind,
    output logic [crp_pkg::BYTE_W-1:0]       out_byte,
    output logic [crp_pkg::NUM_W-1:0]        row,
    output logic [crp_pkg::NUM_W-1:0]        col,
    output logic                             last
);

    localparam int PEND  = SEQ_BYTES - 2;
    localparam int IW    = $clog2(PEND);
    localparam int CNT_W = $clog2(PEND + 1);
    localparam int CW    = $clog2((1 << crp_pkg::LIMIT_W) + SEQ_BYTES);
    localparam int MAC_W = crp_pkg::NUM_W + 4;

    typedef enum logic [2:0] {
        P_ROW0,
        P_ROW,
        P_COL0,
        P_COL,
        P_TAIL,
        P_BAD
    } phase_t;

    logic                       cmd_in_reg;
    logic [crp_pkg::BYTE_W-1:0] byte_in_reg;
    logic [crp_pkg::BYTE_W-1:0] pend_buf [PEND];
    logic [CNT_W-1:0]           pend_cnt_reg, pend_cnt_next;
    logic [IW-1:0]              flush_idx_reg;
    logic [CW-1:0]              carried_reg, carried_next;
    phase_t                     phase_reg, phase_next;
    logic [crp_pkg::NUM_W-1:0]  row_reg, row_next;
    logic [crp_pkg::NUM_W-1:0]  col_reg, col_next;

    logic                       out_valid_reg, out_valid_next;
    crp_pkg::kind_t             kind_reg, kind_next;
    logic [crp_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [crp_pkg::NUM_W-1:0]  row_out_reg, row_out_next;
    logic [crp_pkg::NUM_W-1:0]  col_out_reg, col_out_next;
    logic                       last_reg, last_next;

    logic                       is_digit;
    logic                       is_semi;
    logic                       ok;
    logic [3:0]                 digit;
    logic [crp_pkg::NUM_W-1:0]  mac_src;
    logic [MAC_W-1:0]           mac_sum;
    logic [crp_pkg::NUM_W-1:0]  mac_sat;
    logic [CW-1:0]              carried_after;
    logic [crp_pkg::BYTE_W-1:0] buf_rd;

    // Byte classification
    always_comb
    begin
        is_digit = (byte_in_reg >= crp_pkg::CHAR_0) && (byte_in_reg <= crp_pkg::CHAR_9);
        is_semi  = (byte_in_reg == crp_pkg::CHAR_SEMI);
        digit    = 4'(byte_in_reg - crp_pkg::CHAR_0);
        if (pend_cnt_reg == CNT_W'(1))
        begin
            ok = (byte_in_reg == crp_pkg::CHAR_LBRK);
        end
        else
        begin
            ok = is_digit || is_semi || (byte_in_reg == crp_pkg::CHAR_R);
        end
    end

    // Saturating decimal accumulate, shared by row and column
    always_comb
    begin
        mac_src = ((phase_reg == P_ROW0) || (phase_reg == P_ROW)) ? row_reg : col_reg;
        mac_sum = ({4'b0, mac_src} << 3) + ({4'b0, mac_src} << 1)
                + {{(MAC_W-4){1'b0}}, digit};
        mac_sat = (mac_sum > MAC_W'(crp_pkg::NUM_MAX)) ? crp_pkg::NUM_MAX
                                                        : mac_sum[crp_pkg::NUM_W-1:0];
    end

    assign carried_after = carried_reg + CW'(pend_cnt_reg)
                         + CW'(byte_in_reg != crp_pkg::CHAR_ESC);
    assign buf_rd        = pend_buf[flush_idx_reg];

    always_comb
    begin
        status.fail_pre   = (cmd_in_reg == crp_pkg::CMD_TIMEOUT)
                          || (carried_reg >= CW'(carry_limit));
        status.empty      = (pend_cnt_reg == '0);
        status.is_esc     = (byte_in_reg == crp_pkg::CHAR_ESC);
        status.fits       = ok && (pend_cnt_reg < CNT_W'(PEND));
        status.is_r       = (byte_in_reg == crp_pkg::CHAR_R);
        status.parse_ok   = (phase_reg == P_COL) || (phase_reg == P_TAIL);
        status.post_fail  = (carried_after >= CW'(carry_limit));
        status.flush_last = (CNT_W'(flush_idx_reg) == (pend_cnt_reg - CNT_W'(1)));
        status.slot_free  = !out_valid_reg || !out_stall;
    end

    // Pending count, parse state and carried count
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        phase_next    = phase_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        carried_next  = carried_reg;

        unique case (cmd.pend_op)
            crp_pkg::PEND_HOLD:
            begin
            end
            crp_pkg::PEND_APPEND:
            begin
                pend_cnt_next = pend_cnt_reg + CNT_W'(1);
                if (is_digit)
                begin
                    unique case (phase_reg)
                        P_ROW0, P_ROW:
                        begin
                            row_next   = mac_sat;
                            phase_next = P_ROW;
                        end
                        P_COL0, P_COL:
                        begin
                            col_next   = mac_sat;
                            phase_next = P_COL;
                        end
                        P_TAIL, P_BAD:
                        begin
                        end
                    endcase
                end
                else if (is_semi)
                begin
                    unique case (phase_reg)
                        P_ROW:          phase_next = P_COL0;
                        P_COL, P_TAIL:  phase_next = P_TAIL;
                        P_ROW0, P_COL0,
                        P_BAD:          phase_next = P_BAD;
                    endcase
                end
            end
            crp_pkg::PEND_START:
            begin
                pend_cnt_next = CNT_W'(1);
                phase_next    = P_ROW0;
                row_next      = '0;
                col_next      = '0;
            end
            crp_pkg::PEND_CLEAR:
            begin
                pend_cnt_next = '0;
            end
        endcase

        if ((cmd.emit == crp_pkg::EMIT_BUF) || (cmd.emit == crp_pkg::EMIT_BYTE))
        begin
            carried_next = carried_reg + CW'(1);
        end
        if (cmd.end_wait)
        begin
            pend_cnt_next = '0;
            carried_next  = '0;
        end
    end

    // Result slot
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        out_byte_next  = out_byte_reg;
        row_out_next   = row_out_reg;
        col_out_next   = col_out_reg;
        last_next      = last_reg;
        if (cmd.emit != crp_pkg::EMIT_NONE)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.last;
            out_byte_next  = '0;
            row_out_next   = '0;
            col_out_next   = '0;
            unique case (cmd.emit)
                crp_pkg::EMIT_BUF:
                begin
                    kind_next     = crp_pkg::KIND_CARRY;
                    out_byte_next = buf_rd;
                end
                crp_pkg::EMIT_BYTE:
                begin
                    kind_next     = crp_pkg::KIND_CARRY;
                    out_byte_next = byte_in_reg;
                end
                crp_pkg::EMIT_REPORT:
                begin
                    kind_next    = crp_pkg::KIND_REPORT;
                    row_out_next = row_reg;
                    col_out_next = col_reg;
                end
                crp_pkg::EMIT_FAIL, crp_pkg::EMIT_NONE:
                begin
                    kind_next = crp_pkg::KIND_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg  <= '0;
            carried_reg   <= '0;
            flush_idx_reg <= '0;
            phase_reg     <= P_ROW0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_cnt_reg  <= pend_cnt_next;
            carried_reg   <= carried_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cmd.flush_init)
            begin
                flush_idx_reg <= '0;
            end
            else if (cmd.emit == crp_pkg::EMIT_BUF)
            begin
                flush_idx_reg <= flush_idx_reg + IW'(1);
            end
        end
    end

    // Payload and buffer: no reset
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        row_out_reg  <= row_out_next;
        col_out_reg  <= col_out_next;
        last_reg     <= last_next;
        if (cmd.load_in)
        begin
            cmd_in_reg  <= command;
            byte_in_reg <= data_byte;
        end
        if (cmd.pend_op == crp_pkg::PEND_APPEND)
        begin
            pend_buf[pend_cnt_reg[IW-1:0]] <= byte_in_reg;
        end
        else if (cmd.pend_op == crp_pkg::PEND_START)
        begin
            pend_buf[0] <= crp_pkg::CHAR_ESC;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = out_byte_reg;
    assign row       = row_out_reg;
    assign col       = col_out_reg;
    assign last      = last_reg;

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= CNT_W'(PEND))
        else $error("pending count beyond buffer depth");

    a_report_parsed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit == crp_pkg::EMIT_REPORT |-> status.parse_ok)
        else $error("report emitted without a complete row and column");

    a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit == crp_pkg::EMIT_BUF |-> CNT_W'(flush_idx_reg) < pend_cnt_reg)
        else $error("flush read beyond pending bytes");

    a_carry_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg != crp_pkg::KIND_CARRY) |-> out_byte_reg == '0)
        else $error("non-carry result carries a byte");

endmodule : crp_datapath
`default_nettype wire

// ===== design/crp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crp_ctrl
// Sequencer for the parser: takes one item, decides its case, then steps the
// datapath through the results one transfer at a time.
// ----------------------------------------------------------------------------
module crp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire crp_pkg::crp_status_t status,
    output crp_pkg::crp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FLUSH,
        S_BYTE,
        S_REPORT,
        S_FAIL
    } state_t;

    state_t state_reg, state_next;
    logic   post_fail_reg, post_fail_next;

    always_comb
    begin
        state_next     = state_reg;
        post_fail_next = post_fail_reg;
        cmd            = '{load_in: 1'b0, flush_init: 1'b0,
                           pend_op: crp_pkg::PEND_HOLD, emit: crp_pkg::EMIT_NONE,
                           last: 1'b0, end_wait: 1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.flush_init = 1'b1;
                post_fail_next = status.post_fail;
                priority if (status.fail_pre)
                begin
                    state_next = S_FAIL;
                end
                else if (status.empty)
                begin
                    if (status.is_esc)
                    begin
                        cmd.pend_op = crp_pkg::PEND_START;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BYTE;
                    end
                end
                else if (status.fits && !status.is_r)
                begin
                    cmd.pend_op = crp_pkg::PEND_APPEND;
                    state_next  = S_IDLE;
                end
                else if (status.fits && status.parse_ok)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = crp_pkg::EMIT_BUF;
                    if (status.flush_last)
                    begin
                        cmd.last    = status.is_esc && !post_fail_reg;
                        cmd.pend_op = (status.is_esc && !post_fail_reg) ? crp_pkg::PEND_START
                                                                        : crp_pkg::PEND_CLEAR;
                        priority if (!status.is_esc)
                        begin
                            state_next = S_BYTE;
                        end
                        else if (post_fail_reg)
                        begin
                            state_next = S_FAIL;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_BYTE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = crp_pkg::EMIT_BYTE;
                    cmd.last   = !post_fail_reg;
                    state_next = post_fail_reg ? S_FAIL : S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit     = crp_pkg::EMIT_REPORT;
                    cmd.last     = 1'b1;
                    cmd.end_wait = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (status.slot_free)
                begin
                    cmd.emit     = crp_pkg::EMIT_FAIL;
                    cmd.last     = 1'b1;
                    cmd.end_wait = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            post_fail_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            post_fail_reg <= post_fail_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit != crp_pkg::EMIT_NONE |-> status.slot_free)
        else $error("result written over an untaken result");

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DECIDE)
        else $error("accepted item not decided next cycle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit != crp_pkg::EMIT_NONE && cmd.last |=> state_reg == S_IDLE)
        else $error("final result did not end the item");

endmodule : crp_ctrl
`default_nettype wire

// ===== design/cursor_report_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_report_parser
// Watches terminal input for ESC [ row ; col R and turns it into a position
// report; all other bytes pass on as carried bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, command, data_byte): one transfer per
//   received byte, or a timeout command. Output channel (out_valid /
//   out_stall, kind, out_byte, row, col, last): zero to sixteen results per
//   input, the final one flagged by last.
//   cfg_write / cfg_data set carry_limit; write only while the block is idle.
// Sequence:
//   An input is taken in the idle cycle, classified in the next, then each
//   result is written through the output register while the slot is free. An
//   input that only starts or extends a candidate sequence writes no result;
//   one that flushes a full candidate writes each pending byte in turn. The
//   sequencer handles one input at a time; the serial flush of the pending
//   buffer sets the worst case.
// Reset: pending sequence and carried count clear, carry_limit returns to
//   256, no result is held.
// Stall: a stalled result holds in the output register and the sequencer
//   waits; in_stall stays high until the input's last result is written.
// ----------------------------------------------------------------------------
module cursor_report_parser #(
    parameter int SEQ_BYTES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [crp_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        command,
    input  wire logic [crp_pkg::BYTE_W-1:0]  data_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [crp_pkg::KIND_W-1:0]       kind,
    output logic [crp_pkg::BYTE_W-1:0]       out_byte,
    output logic [crp_pkg::NUM_W-1:0]        row,
    output logic [crp_pkg::NUM_W-1:0]        col,
    output logic                             last
);

    logic [crp_pkg::LIMIT_W-1:0] carry_limit_reg, carry_limit_next;
    crp_pkg::crp_cmd_t           cmd;
    crp_pkg::crp_status_t        status;

    // Carry limit register: take the written value as is
    assign carry_limit_next = cfg_write ? cfg_data : carry_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_limit_reg <= crp_pkg::LIMIT_RESET;
        end
        else
        begin
            carry_limit_reg <= carry_limit_next;
        end
    end

    // Sequencer: one input at a time, one result transfer per step
    crp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Buffer, parse, counters and the result register
    crp_datapath #(
        .SEQ_BYTES (SEQ_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .data_byte   (data_byte),
        .carry_limit (carry_limit_reg),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .row         (row),
        .col         (col),
        .last        (last)
    );

endmodule : cursor_report_parser
`default_nettype wire
